// ===== hw/rtl/dtb_pkg.sv =====
// Package for the delay timer bank: result codes, action codes and shared types.
// Used by dtb_order_list, delay_timer_bank and the testbench; depends on nothing else.
`default_nettype none

package dtb_pkg;

	localparam int DEFAULT_TIMER_SLOTS = 8;
	localparam int DELAY_W = 32;
	localparam int TASK_W = 8;

	localparam logic ACT_REGISTER = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_WAKE = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO_DELAY = 2'd1;
	localparam logic [1:0] ST_NO_CONTEXT = 2'd2;
	localparam logic [1:0] ST_BANK_FULL = 2'd3;

	// Commands to the age-ordered slot list.
	typedef struct packed {
		logic insert;
		logic rotate;
		logic drop;
	} ord_cmd_t;

	// One entry of the timer memory.
	typedef struct packed {
		logic [DELAY_W-1:0] remaining;
		logic [TASK_W-1:0] task_id;
	} timer_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dtb_order_list.sv =====
// Age-ordered permutation of timer slot numbers: active slots newest first, free slots after.
// Supports insert of a free slot at the head and rotation of the head, with optional drop, during a tick walk.
// Depends on dtb_pkg.
`default_nettype none

module dtb_order_list #(
	parameter int TIMER_SLOTS = 8,
	parameter int IDX_W = 3,
	parameter int CNT_W = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire dtb_pkg::ord_cmd_t cmd,
	output logic [IDX_W-1:0] head,
	output logic [IDX_W-1:0] free_slot,
	output logic [CNT_W-1:0] count,
	output logic full
);
	import dtb_pkg::*;

	logic [IDX_W-1:0] order_q [TIMER_SLOTS];
	logic [CNT_W-1:0] count_q;

	assign head = order_q[0];
	assign count = count_q;
	assign full = (count_q == CNT_W'(TIMER_SLOTS));
	assign free_slot = full ? '0 : order_q[count_q[IDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < TIMER_SLOTS; p++) begin
				order_q[p] <= IDX_W'(p);
			end
			count_q <= '0;
		end else if (cmd.insert) begin
			order_q[0] <= free_slot;
			for (int p = 1; p < TIMER_SLOTS; p++) begin
				if (CNT_W'(p) <= count_q) begin
					order_q[p] <= order_q[p-1];
				end
			end
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.rotate) begin
			// The head moves to the end of the active region; a dropped head then
			// becomes the first free slot.
			for (int p = 0; p < TIMER_SLOTS; p++) begin
				if (CNT_W'(p + 1) == count_q) begin
					order_q[p] <= order_q[0];
				end else if (p < TIMER_SLOTS - 1) begin
					if (CNT_W'(p + 1) < count_q) begin
						order_q[p] <= order_q[p+1];
					end
				end
			end
			if (cmd.drop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/delay_timer_bank.sv =====
// Top level of the delay timer bank: command port, timer memory and tick walk sequencer.
// Depends on dtb_pkg and dtb_order_list.
//
// Channel      Signals                                          Transfer
// command      start, busy, action, task_id, task_present,      start high, busy low
//              delay_ticks
// result       result_valid, kind, status, woken_task, last     result_valid high, one cycle
// config       cfg_wr_en, cfg_wr_data                           cfg_wr_en high
//
// A register command's status appears in the next cycle and busy stays low.
// A tick walks the stored timers in age order, newest first, each with a memory read state
// and a write-back state, then a closing state; with the scheduler flag clear or no timers it does nothing.
// Reset clears the slot list and the scheduler flag; the timer memory needs no clearing.
// Results cannot be stalled; each stands on the outputs for exactly one cycle.
`default_nettype none

module delay_timer_bank #(
	parameter int TIMER_SLOTS = dtb_pkg::DEFAULT_TIMER_SLOTS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic cfg_wr_data,
	input wire logic start,
	output logic busy,
	input wire logic action,
	input wire logic [dtb_pkg::TASK_W-1:0] task_id,
	input wire logic task_present,
	input wire logic [dtb_pkg::DELAY_W-1:0] delay_ticks,
	output logic result_valid,
	output logic kind,
	output logic [1:0] status,
	output logic [dtb_pkg::TASK_W-1:0] woken_task,
	output logic last
);
	import dtb_pkg::*;

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_WRITE,
		S_FINISH
	} state_t;

	state_t state_q;
	logic sched_q;
	logic [CNT_W-1:0] left_q;
	logic pend_q;
	logic [TASK_W-1:0] pend_task_q;
	logic result_valid_q;
	logic kind_q;
	logic [1:0] status_q;
	logic [TASK_W-1:0] woken_task_q;
	logic last_q;

	ord_cmd_t ord_cmd;
	logic [IDX_W-1:0] head;
	logic [IDX_W-1:0] free_slot;
	logic [CNT_W-1:0] count;
	logic full;

	timer_entry_t mem [TIMER_SLOTS];
	timer_entry_t rd_s1;
	logic mem_we;
	logic [IDX_W-1:0] mem_addr;
	timer_entry_t mem_wdata;

	logic accept;
	logic [1:0] reg_status;
	logic expired;

	dtb_order_list #(
		.TIMER_SLOTS(TIMER_SLOTS),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_order (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(ord_cmd),
		.head(head),
		.free_slot(free_slot),
		.count(count),
		.full(full)
	);

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		if (delay_ticks == '0) begin
			reg_status = ST_ZERO_DELAY;
		end else if (!task_present) begin
			reg_status = ST_NO_CONTEXT;
		end else if (full) begin
			reg_status = ST_BANK_FULL;
		end else begin
			reg_status = ST_OK;
		end
	end

	assign expired = (rd_s1.remaining == DELAY_W'(1));

	always_comb begin
		ord_cmd.insert = accept && (action == ACT_REGISTER) && (reg_status == ST_OK);
		ord_cmd.rotate = (state_q == S_WRITE);
		ord_cmd.drop = (state_q == S_WRITE) && expired;
	end

	always_comb begin
		mem_we = ord_cmd.insert || (state_q == S_WRITE);
		if (ord_cmd.insert) begin
			mem_addr = free_slot;
			mem_wdata.remaining = delay_ticks;
			mem_wdata.task_id = task_id;
		end else begin
			mem_addr = head;
			mem_wdata.remaining = rd_s1.remaining - DELAY_W'(1);
			mem_wdata.task_id = rd_s1.task_id;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_s1 <= mem[head];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sched_q <= 1'b0;
			left_q <= '0;
			pend_q <= 1'b0;
			pend_task_q <= '0;
			result_valid_q <= 1'b0;
			kind_q <= KIND_STATUS;
			status_q <= ST_OK;
			woken_task_q <= '0;
			last_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_wr_en) begin
				sched_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == ACT_REGISTER) begin
							result_valid_q <= 1'b1;
							kind_q <= KIND_STATUS;
							status_q <= reg_status;
							woken_task_q <= '0;
							last_q <= 1'b1;
						end else if (sched_q && (count != '0)) begin
							state_q <= S_READ;
							left_q <= count;
							pend_q <= 1'b0;
						end
					end
				end
				S_READ: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					// A wake is held back one step so that the final one can carry last.
					if (expired) begin
						if (pend_q) begin
							result_valid_q <= 1'b1;
							kind_q <= KIND_WAKE;
							status_q <= ST_OK;
							woken_task_q <= pend_task_q;
							last_q <= 1'b0;
						end
						pend_q <= 1'b1;
						pend_task_q <= rd_s1.task_id;
					end
					left_q <= left_q - CNT_W'(1);
					state_q <= (left_q == CNT_W'(1)) ? S_FINISH : S_READ;
				end
				S_FINISH: begin
					if (pend_q) begin
						result_valid_q <= 1'b1;
						kind_q <= KIND_WAKE;
						status_q <= ST_OK;
						woken_task_q <= pend_task_q;
						last_q <= 1'b1;
					end
					pend_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign kind = kind_q;
	assign status = status_q;
	assign woken_task = woken_task_q;
	assign last = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(TIMER_SLOTS))
		else $error("slot count exceeds the bank size");

	a_register_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_REGISTER)) |=>
		(result_valid && (kind == KIND_STATUS) && last))
		else $error("register command without a status result");

	a_wake_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (kind == KIND_WAKE)) |-> $past(busy))
		else $error("wake result outside a tick walk");

endmodule

`default_nettype wire

// ===== verif/delay_timer_bank_tb.sv =====
`timescale 1ns / 100ps
// Testbench for delay_timer_bank: a directed table, then random register and tick transfers,
// every result checked against a behavioral copy of the timer bank kept in this file.
// Depends on dtb_pkg and the delay_timer_bank RTL; reads no files.

module delay_timer_bank_tb;
	import dtb_pkg::*;

	localparam int SLOTS = DEFAULT_TIMER_SLOTS;
	localparam int SETTLE_CYCLES = 2 * SLOTS + 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX = 10;

	typedef enum logic [1:0] {ROW_REG, ROW_TICK, ROW_CFG} row_op_t;

	typedef struct {
		row_op_t op;
		logic [TASK_W-1:0] tid;
		logic flag;
		logic [DELAY_W-1:0] dly;
		bit typed;
		logic [1:0] st;
	} plan_row_t;

	typedef struct packed {
		logic kind;
		logic [1:0] status;
		logic [TASK_W-1:0] woken;
		logic last;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;
	logic start;
	logic busy;
	logic action;
	logic [TASK_W-1:0] task_id;
	logic task_present;
	logic [DELAY_W-1:0] delay_ticks;
	logic result_valid;
	logic kind;
	logic [1:0] status;
	logic [TASK_W-1:0] woken_task;
	logic last;

	bit sched_on;
	bit tmr_live [SLOTS];
	logic [DELAY_W-1:0] tmr_left [SLOTS];
	logic [TASK_W-1:0] tmr_owner [SLOTS];
	int tmr_age [SLOTS];
	outcome_t awaited_q [$];
	plan_row_t plan [$];

	int n_cycles = 0;
	int n_sent = 0;
	int n_directed = 0;
	int n_bad = 0;
	int n_status = 0;
	int n_wakes = 0;
	int n_full = 0;

	delay_timer_bank #(
		.TIMER_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.start(start),
		.busy(busy),
		.action(action),
		.task_id(task_id),
		.task_present(task_present),
		.delay_ticks(delay_ticks),
		.result_valid(result_valid),
		.kind(kind),
		.status(status),
		.woken_task(woken_task),
		.last(last)
	);

	always #2 clk = ~clk;

	function automatic logic [1:0] bank_register(logic [TASK_W-1:0] tid, logic present,
		logic [DELAY_W-1:0] dly);
		int slot;
		slot = -1;
		if (dly == '0)
			return ST_ZERO_DELAY;
		if (!present)
			return ST_NO_CONTEXT;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (!tmr_live[i])
				slot = i;
		if (slot < 0)
			return ST_BANK_FULL;
		for (int i = 0; i < SLOTS; i++)
			if (tmr_live[i])
				tmr_age[i]++;
		tmr_live[slot] = 1'b1;
		tmr_left[slot] = dly;
		tmr_owner[slot] = tid;
		tmr_age[slot] = 0;
		return ST_OK;
	endfunction

	// Expired timers wake youngest first; survivors then get dense ages again.
	function automatic void bank_tick();
		bit gone [SLOTS];
		int fresh_age [SLOTS];
		int n_gone;
		int k;
		outcome_t wake;
		n_gone = 0;
		k = 0;
		if (!sched_on)
			return;
		for (int i = 0; i < SLOTS; i++) begin
			gone[i] = 1'b0;
			if (tmr_live[i]) begin
				tmr_left[i] = tmr_left[i] - 1'b1;
				if (tmr_left[i] == '0) begin
					gone[i] = 1'b1;
					n_gone++;
				end
			end
		end
		for (int r = 0; r < SLOTS; r++)
			for (int i = 0; i < SLOTS; i++)
				if (gone[i] && tmr_age[i] == r) begin
					wake.kind = KIND_WAKE;
					wake.status = ST_OK;
					wake.woken = tmr_owner[i];
					wake.last = (k == n_gone - 1);
					awaited_q.push_back(wake);
					k++;
				end
		for (int i = 0; i < SLOTS; i++)
			if (gone[i])
				tmr_live[i] = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			fresh_age[i] = 0;
			if (tmr_live[i])
				for (int j = 0; j < SLOTS; j++)
					if (tmr_live[j] && tmr_age[j] < tmr_age[i])
						fresh_age[i]++;
		end
		for (int i = 0; i < SLOTS; i++)
			if (tmr_live[i])
				tmr_age[i] = fresh_age[i];
	endfunction

	task automatic send_item(logic act, logic [TASK_W-1:0] tid, logic pres,
		logic [DELAY_W-1:0] dly, int gap, bit typed, logic [1:0] typed_st);
		logic [1:0] st;
		outcome_t res;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		task_id <= tid;
		task_present <= pres;
		delay_ticks <= dly;
		do
			@(posedge clk);
		while (busy);
		n_sent++;
		if (act == ACT_REGISTER) begin
			st = bank_register(tid, pres, dly);
			res.kind = KIND_STATUS;
			res.status = typed ? typed_st : st;
			res.woken = '0;
			res.last = 1'b1;
			awaited_q.push_back(res);
		end else begin
			bank_tick();
		end
		@(negedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (awaited_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_schedule(bit on);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= on;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sched_on = on;
	endtask

	task automatic random_phase(int count);
		bit burst;
		int pick;
		int gap;
		logic [TASK_W-1:0] tid;
		logic [DELAY_W-1:0] dly;
		logic pres;
		burst = 1'b0;
		for (int k = 0; k < count; k++) begin
			if (k % 16 == 0)
				burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : $urandom_range(0, 9);
			pick = $urandom_range(0, 99);
			tid = TASK_W'($urandom);
			dly = $urandom;
			pres = 1'($urandom);
			if (pick < 45) begin
				send_item(ACT_TICK, tid, pres, dly, gap, 1'b0, ST_OK);
			end else if (pick < 85) begin
				send_item(ACT_REGISTER, tid, 1'b1, $urandom_range(1, 8), gap, 1'b0, ST_OK);
			end else if (pick < 92) begin
				send_item(ACT_REGISTER, tid, pres, '0, gap, 1'b0, ST_OK);
			end else begin
				send_item(ACT_REGISTER, tid, 1'b0, dly, gap, 1'b0, ST_OK);
			end
		end
	endtask

	task automatic report_bad(string what, outcome_t want, outcome_t got);
		n_bad++;
		if (n_bad <= REPORT_MAX) begin
			$display("Mismatch (%s) at %0t: expected kind %0d status %0d task %02h last %0d,",
				what, $time, want.kind, want.status, want.woken, want.last);
			$display("    got kind %0d status %0d task %02h last %0d",
				got.kind, got.status, got.woken, got.last);
		end
	endtask

	always @(posedge clk) begin : result_check
		outcome_t want;
		outcome_t got;
		if (arst_n && result_valid) begin
			got = {kind, status, woken_task, last};
			if (got.kind == KIND_WAKE)
				n_wakes++;
			else
				n_status++;
			if (got.kind == KIND_STATUS && got.status == ST_BANK_FULL)
				n_full++;
			if (awaited_q.size() == 0) begin
				report_bad("unexpected result", '0, got);
			end else begin
				want = awaited_q.pop_front();
				if (got.kind !== want.kind || got.status !== want.status ||
					got.woken !== want.woken || got.last !== want.last)
					report_bad("field", want, got);
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		start = 1'b0;
		action = ACT_REGISTER;
		task_id = '0;
		task_present = 1'b0;
		delay_ticks = '0;
		sched_on = 1'b0;

		// Errors and storage before the scheduler runs, then fill the bank and expire its short timers.
		plan.push_back(plan_row_t'{ROW_REG, 8'h00, 1'b1, 32'd0, 1'b1, ST_ZERO_DELAY});
		plan.push_back(plan_row_t'{ROW_REG, 8'h5A, 1'b0, 32'd0, 1'b1, ST_ZERO_DELAY});
		plan.push_back(plan_row_t'{ROW_REG, 8'h5A, 1'b0, 32'd7, 1'b1, ST_NO_CONTEXT});
		plan.push_back(plan_row_t'{ROW_TICK, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_REG, 8'hFF, 1'b1, 32'd1, 1'b1, ST_OK});
		plan.push_back(plan_row_t'{ROW_REG, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK});
		plan.push_back(plan_row_t'{ROW_CFG, 8'h00, 1'b1, 32'd0, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_TICK, 8'hA5, 1'b0, 32'd0, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_REG, 8'h11, 1'b1, 32'd2, 1'b1, ST_OK});
		plan.push_back(plan_row_t'{ROW_REG, 8'h22, 1'b1, 32'd2, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_REG, 8'h33, 1'b1, 32'd1, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_REG, 8'h44, 1'b1, 32'd3, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_REG, 8'h55, 1'b1, 32'd2, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_REG, 8'hAA, 1'b1, 32'd1, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_REG, 8'h11, 1'b1, 32'd1, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_REG, 8'h66, 1'b1, 32'd9, 1'b1, ST_BANK_FULL});
		plan.push_back(plan_row_t'{ROW_REG, 8'h66, 1'b0, 32'd9, 1'b1, ST_NO_CONTEXT});
		plan.push_back(plan_row_t'{ROW_REG, 8'h66, 1'b0, 32'd0, 1'b1, ST_ZERO_DELAY});
		plan.push_back(plan_row_t'{ROW_TICK, 8'h00, 1'b0, 32'd0, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_TICK, 8'h3C, 1'b1, 32'h8000_0001, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_TICK, 8'hC3, 1'b0, 32'h7FFF_FFFE, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_TICK, 8'h00, 1'b1, 32'd5, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_CFG, 8'h00, 1'b0, 32'd0, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_TICK, 8'h12, 1'b1, 32'd3, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_CFG, 8'h00, 1'b1, 32'd0, 1'b0, ST_OK});
		plan.push_back(plan_row_t'{ROW_REG, 8'h77, 1'b1, 32'd1, 1'b1, ST_OK});
		plan.push_back(plan_row_t'{ROW_TICK, 8'hFF, 1'b1, 32'd0, 1'b0, ST_OK});

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_schedule(1'b0);

		foreach (plan[r]) begin
			case (plan[r].op)
				ROW_CFG: begin
					drain_results();
					set_schedule(plan[r].flag);
				end
				ROW_REG: begin
					send_item(ACT_REGISTER, plan[r].tid, plan[r].flag, plan[r].dly,
						$urandom_range(0, 9), plan[r].typed, plan[r].st);
				end
				default: begin
					send_item(ACT_TICK, plan[r].tid, plan[r].flag, plan[r].dly,
						$urandom_range(0, 9), 1'b0, ST_OK);
				end
			endcase
		end
		n_directed = n_sent;

		drain_results();
		set_schedule(1'b1);
		random_phase(90);
		drain_results();
		set_schedule(1'b0);
		random_phase(25);
		drain_results();
		set_schedule(1'b1);
		random_phase(90);
		drain_results();

		$display("Run covered %0d command transfers (%0d directed) over three scheduler phases,",
			n_sent, n_directed);
		$display("checking %0d status results (%0d bank-full refusals) and %0d wake results.",
			n_status, n_full, n_wakes);
		if (n_bad == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/dtb_pkg.sv
hw/rtl/dtb_order_list.sv
hw/rtl/delay_timer_bank.sv
verif/delay_timer_bank_tb.sv
